FILE: rtl/core/bvs_pkg.sv
// bvs_pkg: shared constants and types of the bass voice bank
// request codes, datapath command codes, command and status structs
// no dependencies
package bvs_pkg;

    localparam int VOICES_DEF = 16;
    localparam int DECAY_DEF  = 5000;

    // lowpass, cutoff 17/256, 1/q 240/256, unity dc gain
    localparam logic signed [31:0] DEF_A0 = 32'sd38705846;
    localparam logic signed [31:0] DEF_B1 = 32'sd1649850138;
    localparam logic signed [31:0] DEF_B2 = -32'sd730931698;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_NOTE = 2'd1;
    localparam logic [1:0] REQ_LEN  = 2'd2;
    localparam logic [1:0] REQ_FILT = 2'd3;

    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_CLR  = 5'd1;
    localparam logic [4:0] OP_NOTE = 5'd2;
    localparam logic [4:0] OP_LEN  = 5'd3;
    localparam logic [4:0] OP_FILT = 5'd4;
    localparam logic [4:0] OP_SAW  = 5'd5;
    localparam logic [4:0] OP_MM   = 5'd6;
    localparam logic [4:0] OP_MQ   = 5'd7;
    localparam logic [4:0] OP_MC   = 5'd8;
    localparam logic [4:0] OP_FIX  = 5'd9;
    localparam logic [4:0] OP_MA   = 5'd10;
    localparam logic [4:0] OP_MB1  = 5'd11;
    localparam logic [4:0] OP_MB2  = 5'd12;
    localparam logic [4:0] OP_ACC  = 5'd13;
    localparam logic [4:0] OP_WB   = 5'd14;
    localparam logic [4:0] OP_ADD  = 5'd15;
    localparam logic [4:0] OP_OUT  = 5'd16;

    typedef struct packed {
        logic [4:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic decay;
        logic out_full;
    } t_dp_stat;

endpackage

FILE: rtl/core/bvs_ctrl.sv
// bvs_ctrl: sequencer of the voice bank, steps voices and datapath ops
// depends on bvs_pkg
module bvs_ctrl #(
    parameter int VOICES = bvs_pkg::VOICES_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_req_type,
    input  logic             i_out_ready,
    input  bvs_pkg::t_dp_stat i_stat,
    output bvs_pkg::t_dp_cmd o_cmd,
    output logic [VW-1:0]    o_vidx
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SAW  = 4'd1;
    localparam logic [3:0] S_MM   = 4'd2;
    localparam logic [3:0] S_MQ   = 4'd3;
    localparam logic [3:0] S_MC   = 4'd4;
    localparam logic [3:0] S_FIX  = 4'd5;
    localparam logic [3:0] S_MA   = 4'd6;
    localparam logic [3:0] S_MB1  = 4'd7;
    localparam logic [3:0] S_MB2  = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;
    localparam logic [3:0] S_ADD  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]    r_state, n_state;
    logic [VW-1:0] r_v, n_v;
    logic          last_v;

    assign last_v = (r_v == VW'(VOICES - 1));
    assign o_vidx = r_v;

    always_comb begin
        n_state    = r_state;
        n_v        = r_v;
        o_cmd.op   = bvs_pkg::OP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_req_type)
                        bvs_pkg::REQ_TICK: begin
                            o_cmd.op = bvs_pkg::OP_CLR;
                            n_v      = '0;
                            n_state  = S_SAW;
                        end
                        bvs_pkg::REQ_NOTE: o_cmd.op = bvs_pkg::OP_NOTE;
                        bvs_pkg::REQ_LEN:  o_cmd.op = bvs_pkg::OP_LEN;
                        default:           o_cmd.op = bvs_pkg::OP_FILT;
                    endcase
                end
            end
            S_SAW: begin
                if (!i_stat.active) begin
                    if (last_v) begin
                        n_state = S_FIN;
                    end else begin
                        n_v = r_v + 1'b1;
                    end
                end else begin
                    o_cmd.op = bvs_pkg::OP_SAW;
                    n_state  = i_stat.decay ? S_MM : S_MA;
                end
            end
            S_MM: begin
                o_cmd.op = bvs_pkg::OP_MM;
                n_state  = S_MQ;
            end
            S_MQ: begin
                o_cmd.op = bvs_pkg::OP_MQ;
                n_state  = S_MC;
            end
            S_MC: begin
                o_cmd.op = bvs_pkg::OP_MC;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.op = bvs_pkg::OP_FIX;
                n_state  = S_MA;
            end
            S_MA: begin
                o_cmd.op = bvs_pkg::OP_MA;
                n_state  = S_MB1;
            end
            S_MB1: begin
                o_cmd.op = bvs_pkg::OP_MB1;
                n_state  = S_MB2;
            end
            S_MB2: begin
                o_cmd.op = bvs_pkg::OP_MB2;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = bvs_pkg::OP_ACC;
                n_state  = S_WB;
            end
            S_WB: begin
                o_cmd.op = bvs_pkg::OP_WB;
                n_state  = S_ADD;
            end
            S_ADD: begin
                o_cmd.op = bvs_pkg::OP_ADD;
                if (last_v) begin
                    n_state = S_FIN;
                end else begin
                    n_v     = r_v + 1'b1;
                    n_state = S_SAW;
                end
            end
            S_FIN: begin
                if (!i_stat.out_full || i_out_ready) begin
                    o_cmd.op = bvs_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v     <= '0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == bvs_pkg::OP_OUT) |-> (!i_stat.out_full || i_out_ready))
        else $error("result written over an untaken word");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_req_type == bvs_pkg::REQ_TICK)
        |=> (r_state == S_SAW && r_v == '0))
        else $error("tick did not start at the first voice");

    a_last_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD && last_v) |=> (r_state == S_FIN))
        else $error("voice sweep did not end after the last voice");

endmodule

FILE: rtl/core/bvs_dp.sv
// bvs_dp: per-voice state, shared multiplier, filter and mix datapath
// depends on bvs_pkg
module bvs_dp #(
    parameter int VOICES        = bvs_pkg::VOICES_DEF,
    parameter int DECAY_SAMPLES = bvs_pkg::DECAY_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bvs_pkg::t_dp_cmd   i_cmd,
    input  logic [VW-1:0]      i_vidx,
    output bvs_pkg::t_dp_stat  o_stat,
    input  logic [15:0]        i_spt,
    input  logic [3:0]         i_voice,
    input  logic [31:0]        i_phase_step,
    input  logic [7:0]         i_length_ticks,
    input  logic signed [31:0] i_coef_a0,
    input  logic signed [31:0] i_coef_b1,
    input  logic signed [31:0] i_coef_b2,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [23:0] o_mix_sample
);

    localparam int IW = (VW > 4) ? VW : 4;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / DECAY_SAMPLES);

    logic [23:0]        r_rem [VOICES];
    logic [31:0]        r_ph  [VOICES];
    logic [31:0]        r_inc [VOICES];
    logic signed [15:0] r_x1  [VOICES];
    logic signed [15:0] r_x2  [VOICES];
    logic signed [23:0] r_y1  [VOICES];
    logic signed [23:0] r_y2  [VOICES];
    logic signed [31:0] r_a0  [VOICES];
    logic signed [31:0] r_b1  [VOICES];
    logic signed [31:0] r_b2  [VOICES];

    logic signed [16:0] r_d;
    logic [29:0]        r_m;
    logic [29:0]        r_q;
    logic [63:0]        r_prod;
    logic signed [57:0] r_acc;
    logic signed [23:0] r_y;
    logic signed [31:0] r_sum;
    logic               r_out_valid;
    logic signed [23:0] r_mix;

    logic [IW-1:0]      iv_ext;
    logic               iv_ok;
    logic [VW-1:0]      iv;
    logic signed [16:0] d_saw;
    logic [16:0]        d_mag;
    logic [30:0]        fix_rem;
    logic [29:0]        fix_q;
    logic signed [18:0] s_in;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [57:0] acc_rnd, acc_sh;
    logic signed [23:0] y_sat;
    logic signed [31:0] sum_sh;
    logic signed [23:0] mix_sat;

    assign iv_ext = IW'(i_voice);
    assign iv_ok  = ({1'b0, iv_ext} < (IW + 1)'(VOICES));
    assign iv     = iv_ext[VW-1:0];

    assign o_stat.active   = (r_rem[i_vidx] != 24'd0);
    assign o_stat.decay    = (r_rem[i_vidx] < 24'(DECAY_SAMPLES));
    assign o_stat.out_full = r_out_valid;

    // sawtooth 0.5 - phase in q1.15
    assign d_saw = 17'sd16384 - $signed({2'b00, r_ph[i_vidx][31:17]});
    assign d_mag = r_d[16] ? 17'(-r_d) : 17'(r_d);

    // reciprocal quotient is low by at most one
    assign fix_rem = {1'b0, r_m} - r_prod[30:0];
    assign fix_q   = r_q + 30'(fix_rem >= 31'(DECAY_SAMPLES));

    assign s_in = 19'(r_d) + 19'(r_x1[i_vidx]) + 19'(r_x1[i_vidx])
                + 19'(r_x2[i_vidx]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            bvs_pkg::OP_MM: begin
                mul_a = 34'(d_mag);
                mul_b = 34'(r_rem[i_vidx]);
            end
            bvs_pkg::OP_MQ: begin
                mul_a = 34'(r_prod[29:0]);
                mul_b = 34'(RECIP);
            end
            bvs_pkg::OP_MC: begin
                mul_a = 34'(r_prod[63:32]);
                mul_b = 34'(DECAY_SAMPLES);
            end
            bvs_pkg::OP_MA: begin
                mul_a = 34'(r_a0[i_vidx]);
                mul_b = 34'(s_in);
            end
            bvs_pkg::OP_MB1: begin
                mul_a = 34'(r_b1[i_vidx]);
                mul_b = 34'(r_y1[i_vidx]);
            end
            bvs_pkg::OP_MB2: begin
                mul_a = 34'(r_b2[i_vidx]);
                mul_b = 34'(r_y2[i_vidx]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign acc_rnd = r_acc + 58'sd536870912;
    assign acc_sh  = acc_rnd >>> 30;
    assign y_sat   = (acc_sh > 58'sd8388607)  ? 24'sh7FFFFF :
                     (acc_sh < -58'sd8388608) ? 24'sh800000 : acc_sh[23:0];

    assign sum_sh  = (r_sum + 32'sd2) >>> 2;
    assign mix_sat = (sum_sh > 32'sd8388607)  ? 24'sh7FFFFF :
                     (sum_sh < -32'sd8388608) ? 24'sh800000 : sum_sh[23:0];

    // per-voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICES; i++) begin
                r_rem[i] <= '0;
                r_ph[i]  <= '0;
                r_inc[i] <= '0;
                r_x1[i]  <= '0;
                r_x2[i]  <= '0;
                r_y1[i]  <= '0;
                r_y2[i]  <= '0;
                r_a0[i]  <= bvs_pkg::DEF_A0;
                r_b1[i]  <= bvs_pkg::DEF_B1;
                r_b2[i]  <= bvs_pkg::DEF_B2;
            end
        end else begin
            unique case (i_cmd.op)
                bvs_pkg::OP_NOTE: begin
                    if (iv_ok) begin
                        r_inc[iv] <= i_phase_step;
                        r_ph[iv]  <= '0;
                        r_rem[iv] <= 24'(i_spt);
                    end
                end
                bvs_pkg::OP_LEN: begin
                    if (iv_ok) begin
                        r_rem[iv] <= 24'(i_length_ticks) * 24'(i_spt);
                    end
                end
                bvs_pkg::OP_FILT: begin
                    if (iv_ok) begin
                        r_a0[iv] <= i_coef_a0;
                        r_b1[iv] <= i_coef_b1;
                        r_b2[iv] <= i_coef_b2;
                    end
                end
                bvs_pkg::OP_WB: begin
                    r_ph[i_vidx]  <= r_ph[i_vidx] + r_inc[i_vidx];
                    r_rem[i_vidx] <= r_rem[i_vidx] - 24'd1;
                    r_x2[i_vidx]  <= r_x1[i_vidx];
                    r_x1[i_vidx]  <= 16'(r_d);
                    r_y2[i_vidx]  <= r_y1[i_vidx];
                    r_y1[i_vidx]  <= y_sat;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bvs_pkg::OP_SAW: r_d <= d_saw;
            bvs_pkg::OP_MM:  r_prod <= mul_p[63:0];
            bvs_pkg::OP_MQ: begin
                r_m    <= r_prod[29:0];
                r_prod <= mul_p[63:0];
            end
            bvs_pkg::OP_MC: begin
                r_q    <= r_prod[61:32];
                r_prod <= mul_p[63:0];
            end
            bvs_pkg::OP_FIX: r_d <= r_d[16] ? -17'(fix_q) : 17'(fix_q);
            bvs_pkg::OP_MA:  r_prod <= mul_p[63:0];
            bvs_pkg::OP_MB1: begin
                r_acc  <= $signed(r_prod[57:0]);
                r_prod <= mul_p[63:0];
            end
            bvs_pkg::OP_MB2: begin
                r_acc  <= r_acc + $signed(r_prod[57:0]);
                r_prod <= mul_p[63:0];
            end
            bvs_pkg::OP_ACC: r_acc <= r_acc + $signed(r_prod[57:0]);
            bvs_pkg::OP_WB:  r_y <= y_sat;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.op == bvs_pkg::OP_CLR) begin
            r_sum <= '0;
        end else if (i_cmd.op == bvs_pkg::OP_ADD) begin
            r_sum <= r_sum + 32'(r_y);
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == bvs_pkg::OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == bvs_pkg::OP_OUT) begin
            r_mix <= mix_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mix_sample = r_mix;

endmodule

FILE: rtl/core/bass_voice_bank_synth.sv
// bass_voice_bank_synth: top level of the saw plus biquad voice bank
// holds the apb register, joins bvs_ctrl and bvs_dp; depends on bvs_pkg
//
//  channel  | handshake                 | payload
//  input    | i_in_valid / o_in_ready   | req_type voice phase_step length_ticks coefs
//  output   | o_out_valid / i_out_ready | mix_sample
//  config   | psel penable pwrite pready| paddr pwdata prdata (samples_per_tick)
//
// note, length and filter words are applied from idle, which stays ready
// a tick steps voices in turn: a silent voice is skipped, an active one runs saw and
// filter, scaled first in its decay tail; one shared 34x34 multiplier serves all tick
// products; reset clears voice state, loads default coefficients, no clearing pass
// a finished mix word waits in the output register; a new tick stalls at the end
// only while that register is still full
module bass_voice_bank_synth #(
    parameter int VOICES        = bvs_pkg::VOICES_DEF,
    parameter int DECAY_SAMPLES = bvs_pkg::DECAY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [3:0]         i_voice,
    input  logic [31:0]        i_phase_step,
    input  logic [7:0]         i_length_ticks,
    input  logic signed [31:0] i_coef_a0,
    input  logic signed [31:0] i_coef_b1,
    input  logic signed [31:0] i_coef_b2,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_mix_sample,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [15:0]       r_spt;
    bvs_pkg::t_dp_cmd  cmd;
    bvs_pkg::t_dp_stat stat;
    logic [VW-1:0]     vidx;

    assign pready = 1'b1;
    // the one register fills the whole address range
    assign prdata = {16'd0, r_spt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt <= 16'd1;
        end else if (psel && penable && pwrite && pready && (paddr[1:0] <= 2'd3)) begin
            r_spt <= pwdata[15:0];
        end
    end

    bvs_ctrl #(
        .VOICES (VOICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_vidx      (vidx)
    );

    bvs_dp #(
        .VOICES        (VOICES),
        .DECAY_SAMPLES (DECAY_SAMPLES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_vidx         (vidx),
        .o_stat         (stat),
        .i_spt          (r_spt),
        .i_voice        (i_voice),
        .i_phase_step   (i_phase_step),
        .i_length_ticks (i_length_ticks),
        .i_coef_a0      (i_coef_a0),
        .i_coef_b1      (i_coef_b1),
        .i_coef_b2      (i_coef_b2),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_mix_sample   (o_mix_sample)
    );

endmodule
